/* src/fbfd_pkg.sv */
// Shared types, constants and checksum function for the five-byte frame deframer.
package fbfd_pkg;

  localparam int FrameLen = 5;
  localparam int HeldLen  = FrameLen - 1;
  localparam int CheckMod = 255;
  localparam int SumW     = 10;

  typedef logic [7:0]        byte_t;
  typedef logic [2:0]        fill_t;
  typedef logic [1:0]        held_idx_t;
  typedef logic signed [15:0] value_t;

  localparam byte_t StartByteReset = 8'd253;

  // 255 - ((reg + high + low) mod 255); the sum never reaches four times the modulus
  function automatic byte_t frame_checksum(byte_t reg_num, byte_t hi, byte_t lo);
    logic [SumW-1:0] sum;
    logic [SumW-1:0] rem;
    sum = {2'b00, reg_num} + {2'b00, hi} + {2'b00, lo};
    if (sum >= SumW'(3 * CheckMod)) begin
      rem = sum - SumW'(3 * CheckMod);
    end else if (sum >= SumW'(2 * CheckMod)) begin
      rem = sum - SumW'(2 * CheckMod);
    end else if (sum >= SumW'(CheckMod)) begin
      rem = sum - SumW'(CheckMod);
    end else begin
      rem = sum;
    end
    return byte_t'(SumW'(CheckMod) - rem);
  endfunction

endpackage

/* src/fbfd_if.sv */
// Channel interfaces for received bytes, decoded results and the start byte register.
interface fbfd_rx_if
  import fbfd_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fbfd_res_if
  import fbfd_pkg::*;
;
  logic   valid;
  logic   ready;
  byte_t  register_number;
  value_t register_value;

  modport source (output valid, output register_number, output register_value, input ready);
  modport sink   (input valid, input register_number, input register_value, output ready);
endinterface

interface fbfd_cfg_if
  import fbfd_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t start_byte;

  modport source (output valid, output start_byte, input ready);
  modport sink   (input valid, input start_byte, output ready);
endinterface

/* src/five_byte_frame_deframer.sv */
// A byte is registered, then decoded into the result register.
// Throughput: one byte per cycle while no result is left waiting; the window update and the
// checksum compare fit in one stage between the input register and the result register.
// A result left waiting stalls the input once a byte is held behind it.
// Reset clears the window fill, both valid flags and sets the start byte to 253.
module five_byte_frame_deframer
  import fbfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fbfd_cfg_if.sink   cfg_i,
  fbfd_rx_if.sink    rx_i,
  fbfd_res_if.source res_o
);

  byte_t  start_q;
  logic   in_vld_q;
  byte_t  in_byte_q;
  byte_t  win_q [HeldLen];
  byte_t  win_d [HeldLen];
  fill_t  fill_q;
  fill_t  fill_d;
  logic   out_vld_q;
  byte_t  out_num_q;
  value_t out_val_q;

  logic   advance;
  logic   res_load;
  logic   match;
  byte_t  frame [FrameLen];
  fill_t  shift;

  assign cfg_i.ready = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready  = !in_vld_q || advance;

  assign res_o.valid           = out_vld_q;
  assign res_o.register_number = out_num_q;
  assign res_o.register_value  = out_val_q;

  always_comb begin
    for (int i = 0; i < HeldLen; i++) begin
      frame[i] = win_q[i];
    end
    frame[HeldLen] = in_byte_q;
  end

  assign match = (frame[0] == start_q) &&
                 (frame_checksum(frame[1], frame[2], frame[3]) == frame[4]);

  // first frame byte after the leading one that equals the start byte
  always_comb begin
    if (frame[1] == start_q) begin
      shift = 3'd1;
    end else if (frame[2] == start_q) begin
      shift = 3'd2;
    end else if (frame[3] == start_q) begin
      shift = 3'd3;
    end else if (frame[4] == start_q) begin
      shift = 3'd4;
    end else begin
      shift = 3'd0;
    end
  end

  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    res_load = 1'b0;
    if (advance) begin
      if (fill_q == '0 && in_byte_q != start_q) begin
        // drop leading noise
        fill_d = fill_q;
      end else if (fill_q < fill_t'(HeldLen)) begin
        win_d[fill_q[1:0]] = in_byte_q;
        fill_d             = fill_q + 3'd1;
      end else if (match) begin
        res_load = 1'b1;
        fill_d   = '0;
      end else begin
        // drop bytes up to the next start byte and realign there, or empty the window if none
        case (shift)
          3'd1: begin
            for (int j = 0; j < 4; j++) win_d[j] = frame[j + 1];
            fill_d = 3'd4;
          end
          3'd2: begin
            for (int j = 0; j < 3; j++) win_d[j] = frame[j + 2];
            fill_d = 3'd3;
          end
          3'd3: begin
            for (int j = 0; j < 2; j++) win_d[j] = frame[j + 3];
            fill_d = 3'd2;
          end
          3'd4: begin
            win_d[0] = frame[4];
            fill_d   = 3'd1;
          end
          default: begin
            fill_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= StartByteReset;
      in_vld_q  <= 1'b0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        start_q <= cfg_i.start_byte;
      end
      if (rx_i.valid && rx_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      fill_q <= fill_d;
      if (advance) begin
        out_vld_q <= res_load;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    win_q <= win_d;
    if (res_load) begin
      out_num_q <= frame[1];
      out_val_q <= value_t'({frame[2], frame[3]});
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fill_t'(HeldLen))
    else $error("window fill beyond held depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (fill_q == '0) && out_vld_q)
    else $error("emitted frame did not clear window");

  a_noise_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fill_q == '0 && in_byte_q != start_q) |=> fill_q == '0)
    else $error("noise byte entered empty window");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_vld_q && out_vld_q && !res_o.ready))
    else $error("input stalled without a held result");

  a_no_emit_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> fill_q == fill_t'(HeldLen))
    else $error("result from an incomplete window");

endmodule
